FILE: design/plt_pkg.sv
// ----------------------------------------------------------------------------
// plt_pkg
// Shared types, codes and default sizes for the pin link table unit.
// ----------------------------------------------------------------------------
package plt_pkg;

  // default sizes
  localparam int NUM_PINS_DEF           = 64;
  localparam int MAX_LINKS_DEF          = 8;
  localparam int NUM_EVENT_TYPES_DEF    = 8;
  localparam int OVERFLOW_EVENT_BIT_DEF = 0;

  // fixed field widths
  localparam int LINK_W = 17;  // other pin, parameter, type
  localparam int PIU_W  = 7;   // pins in use register

  // operation codes
  typedef enum logic [1:0] {
    FUNC_ADD_LINK    = 2'd0,
    FUNC_ADD_EVENT   = 2'd1,
    FUNC_QUERY_EVENT = 2'd2,
    FUNC_CLEAR       = 2'd3
  } func_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;    // latch item, start table read
    logic meta_load;  // take table read data, set up scan
    logic scan_en;    // step the duplicate scan
    logic update;     // write tables, form result
    logic out_load;   // move result into output register
  } plt_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic need_scan;  // item is an add link on a valid pin
    logic scan_done;  // scan finished or found a match
    logic out_free;   // output register can take a result
  } plt_status_t;

endpackage

FILE: design/plt_ctrl.sv
// ----------------------------------------------------------------------------
// plt_ctrl
// Sequencer for one item at a time: table read, duplicate scan, update, output.
// ----------------------------------------------------------------------------
module plt_ctrl
  import plt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output plt_cmd_t    cmd,
  input  plt_status_t status
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_META   = 5'b00010,
    S_SCAN   = 5'b00100,
    S_UPDATE = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_META;
        end
      end
      S_META: begin
        cmd.meta_load = 1'b1;
        state_nxt     = status.need_scan ? S_SCAN : S_UPDATE;
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (status.scan_done) begin
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = S_FINISH;
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: design/plt_dp.sv
// ----------------------------------------------------------------------------
// plt_dp
// Per-pin tables, link store, duplicate scan and output register.
// ----------------------------------------------------------------------------
module plt_dp
  import plt_pkg::*;
#(
  parameter int NUM_PINS           = NUM_PINS_DEF,
  parameter int MAX_LINKS          = MAX_LINKS_DEF,
  parameter int NUM_EVENT_TYPES    = NUM_EVENT_TYPES_DEF,
  parameter int OVERFLOW_EVENT_BIT = OVERFLOW_EVENT_BIT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [PIU_W-1:0]  cfg_wdata,
  input  logic [1:0]        in_func,
  input  logic [5:0]        in_pin,
  input  logic [7:0]        in_far_pin,
  input  logic [7:0]        in_link_param,
  input  logic              in_link_type,
  input  logic [2:0]        in_event_code,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_duplicate,
  output logic              out_limit_hit,
  output logic              out_event_present,
  output logic [3:0]        out_link_count,
  output logic [2:0]        out_slot_written,
  input  plt_cmd_t          cmd,
  output plt_status_t       status
);

  localparam int PIN_W  = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;
  localparam int CW     = $clog2(MAX_LINKS + 1);
  localparam int PW     = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
  localparam int EW     = NUM_EVENT_TYPES;
  localparam int MW     = EW + CW + PW;
  localparam int DEPTH  = NUM_PINS * MAX_LINKS;
  localparam int LA     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [8:0]    NPINS    = 9'(NUM_PINS);
  localparam logic [5:0]    NEVT     = 6'(NUM_EVENT_TYPES);
  localparam logic [CW-1:0] CNT_FULL = CW'(MAX_LINKS);
  localparam logic [CW:0]   MAXL_X   = (CW + 1)'(MAX_LINKS);
  localparam logic [EW-1:0] OVF_MASK =
    (OVERFLOW_EVENT_BIT < NUM_EVENT_TYPES) ? (EW'(1) << OVERFLOW_EVENT_BIT) : '0;

  // configuration
  logic [PIU_W-1:0] piu_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      piu_r <= PIU_W'(64);
    end else if (cfg_we) begin
      piu_r <= cfg_wdata;
    end
  end

  // latched item
  func_t            func_r;
  logic [5:0]       pin_r;
  logic [LINK_W-1:0] link_r;
  logic [2:0]       ev_r;
  logic [PIN_W-1:0] in_pin_idx, pin_idx_r;

  assign in_pin_idx = PIN_W'(in_pin);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r    <= func_t'(in_func);
      pin_r     <= in_pin;
      pin_idx_r <= in_pin_idx;
      link_r    <= {in_far_pin, in_link_param, in_link_type};
      ev_r      <= in_event_code;
    end
  end

  logic pin_ok, ev_ok;
  assign pin_ok = (9'(pin_r) < NPINS);
  assign ev_ok  = (6'(ev_r) < NEVT);

  // per-pin table: mask, count, position, with a valid bit per pin
  logic [MW-1:0]       meta_mem [NUM_PINS];
  logic [MW-1:0]       meta_rdata_r;
  logic                meta_vld_rd_r;
  logic [NUM_PINS-1:0] valid_r;
  logic                meta_we;
  logic [MW-1:0]       meta_wdata;
  logic                do_clear;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      meta_rdata_r <= meta_mem[in_pin_idx];
    end
    if (meta_we) begin
      meta_mem[pin_idx_r] <= meta_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      meta_vld_rd_r <= valid_r[in_pin_idx];
    end
  end

  // valid bits: set on a table write, dropped for the cleared pin range
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (do_clear) begin
      for (int i = 0; i < NUM_PINS; i++) begin
        if (9'(i) < 9'(piu_r)) begin
          valid_r[i] <= 1'b0;
        end
      end
    end else if (meta_we) begin
      valid_r[pin_idx_r] <= 1'b1;
    end
  end

  // table entry as read, unwritten pins read as zero
  logic [EW-1:0] mask_m;
  logic [CW-1:0] cnt_m;
  logic [PW-1:0] pos_m;
  logic [CW:0]   start_x;

  always_comb begin
    if (meta_vld_rd_r) begin
      {mask_m, cnt_m, pos_m} = meta_rdata_r;
    end else begin
      {mask_m, cnt_m, pos_m} = '0;
    end
    start_x = (CW + 1)'(pos_m) + MAXL_X - (CW + 1)'(cnt_m);
    if (start_x >= MAXL_X) begin
      start_x = start_x - MAXL_X;
    end
  end

  logic [EW-1:0] mask_r;
  logic [CW-1:0] cnt_r;
  logic [PW-1:0] pos_r;
  logic [PW-1:0] start_r;
  logic [LA-1:0] base_r;

  always_ff @(posedge clk) begin
    if (cmd.meta_load) begin
      mask_r  <= mask_m;
      cnt_r   <= cnt_m;
      pos_r   <= pos_m;
      start_r <= PW'(start_x);
      base_r  <= LA'(32'(pin_idx_r) * 32'(MAX_LINKS));
    end
  end

  // link store
  logic [LINK_W-1:0] link_mem [DEPTH];
  logic [LINK_W-1:0] link_rdata_r;
  logic              link_re, link_we;
  logic [LA-1:0]     link_raddr, link_waddr;

  always_ff @(posedge clk) begin
    if (link_re) begin
      link_rdata_r <= link_mem[link_raddr];
    end
    if (link_we) begin
      link_mem[link_waddr] <= link_r;
    end
  end

  // duplicate scan: one read issued and one compare per cycle
  logic [CW-1:0] iss_r, cmp_r;
  logic          pend_r, hit_r;
  logic [CW:0]   slot_x;

  always_comb begin
    slot_x = (CW + 1)'(start_r) + (CW + 1)'(iss_r);
    if (slot_x >= MAXL_X) begin
      slot_x = slot_x - MAXL_X;
    end
    link_raddr = base_r + LA'(slot_x);
    link_re    = cmd.scan_en && (iss_r < cnt_r) && !hit_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.meta_load) begin
      iss_r  <= '0;
      cmp_r  <= '0;
      pend_r <= 1'b0;
      hit_r  <= 1'b0;
    end else if (cmd.scan_en) begin
      pend_r <= link_re;
      if (link_re) begin
        iss_r <= iss_r + CW'(1);
      end
      if (pend_r) begin
        cmp_r <= cmp_r + CW'(1);
        hit_r <= hit_r | (link_rdata_r == link_r);
      end
    end
  end

  // update: new table values and result fields
  logic [PW-1:0] wpos, npos;
  logic [CW-1:0] ncnt, wp1;
  logic [EW-1:0] nmask, ev_bit, mask_sh;
  logic          r_dup, r_lim, r_pres;
  logic [3:0]    r_cnt;
  logic [2:0]    r_slot;
  logic          full;

  always_comb begin
    full     = (cnt_r >= CNT_FULL);
    wpos     = full ? '0 : pos_r;
    ncnt     = full ? CW'(1) : cnt_r + CW'(1);
    wp1      = CW'(wpos) + CW'(1);
    npos     = (wp1 == CNT_FULL) ? '0 : PW'(wp1);
    ev_bit   = ev_ok ? (EW'(1) << ev_r) : '0;
    mask_sh  = mask_r >> ev_r;
    nmask    = mask_r;
    meta_wdata = {mask_r, cnt_r, pos_r};
    meta_we  = 1'b0;
    link_we  = 1'b0;
    do_clear = 1'b0;
    r_dup    = 1'b0;
    r_lim    = 1'b0;
    r_pres   = 1'b0;
    r_cnt    = 4'(cnt_r);
    r_slot   = '0;
    link_waddr = base_r + LA'(wpos);
    unique case (func_r)
      FUNC_ADD_LINK: begin
        if (hit_r) begin
          r_dup = 1'b1;
        end else begin
          nmask      = full ? (mask_r | OVF_MASK) : mask_r;
          meta_wdata = {nmask, ncnt, npos};
          meta_we    = cmd.update && pin_ok;
          link_we    = cmd.update && pin_ok;
          r_lim      = full;
          r_cnt      = 4'(ncnt);
          r_slot     = 3'(wpos);
        end
      end
      FUNC_ADD_EVENT: begin
        nmask      = mask_r | ev_bit;
        meta_wdata = {nmask, cnt_r, pos_r};
        meta_we    = cmd.update && pin_ok;
      end
      FUNC_QUERY_EVENT: begin
        r_pres = ev_ok & mask_sh[0];
      end
      FUNC_CLEAR: begin
        do_clear = cmd.update;
        if (9'(pin_r) < 9'(piu_r)) begin
          r_cnt = '0;
        end
      end
      default: begin
        r_cnt = '0;
      end
    endcase
    // an out of range pin reports nothing
    if (!pin_ok) begin
      r_dup  = 1'b0;
      r_lim  = 1'b0;
      r_pres = 1'b0;
      r_cnt  = '0;
      r_slot = '0;
    end
  end

  // result hold between update and output
  logic       res_dup_r, res_lim_r, res_pres_r;
  logic [3:0] res_cnt_r;
  logic [2:0] res_slot_r;

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      res_dup_r  <= r_dup;
      res_lim_r  <= r_lim;
      res_pres_r <= r_pres;
      res_cnt_r  <= r_cnt;
      res_slot_r <= r_slot;
    end
  end

  // output register
  logic       out_valid_r;
  logic       out_dup_r, out_lim_r, out_pres_r;
  logic [3:0] out_cnt_r;
  logic [2:0] out_slot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_dup_r  <= res_dup_r;
      out_lim_r  <= res_lim_r;
      out_pres_r <= res_pres_r;
      out_cnt_r  <= res_cnt_r;
      out_slot_r <= res_slot_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_duplicate     = out_dup_r;
  assign out_limit_hit     = out_lim_r;
  assign out_event_present = out_pres_r;
  assign out_link_count    = out_cnt_r;
  assign out_slot_written  = out_slot_r;

  // status
  assign status.need_scan = (func_r == FUNC_ADD_LINK) && pin_ok;
  assign status.scan_done = hit_r || (cmp_r == cnt_r);
  assign status.out_free  = !out_valid_r || out_ready;

endmodule

FILE: design/pin_link_table_unit.sv
// ----------------------------------------------------------------------------
// pin_link_table_unit
// Per-pin link table with duplicate check and per-pin event bit mask.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready) carries one item: an operation, a pin
//   and the link or event fields. Each item gives exactly one result on the
//   output channel (out_valid / out_ready).
//   cfg_we / cfg_wdata write the pins-in-use count used by the clear
//   operation; write it only while the unit is idle.
//   One item is worked on at a time. Add event, query event and clear skip
//   the scan. Add link on a valid pin first scans the links stored for the
//   pin, so it takes longer the more links are stored; a duplicate found
//   early ends it sooner: the scan reads the link store through its one
//   read port, one entry per cycle.
//   The result is held in an output register; the unit accepts the next item
//   while a result waits, and stalls before its own result if the previous
//   one is still not taken.
//   Reset clears the per-pin valid bits, so every pin reads as
//   an empty table with no events. The link store itself is not cleared.
// ----------------------------------------------------------------------------
module pin_link_table_unit
  import plt_pkg::*;
#(
  parameter int NUM_PINS           = NUM_PINS_DEF,
  parameter int MAX_LINKS          = MAX_LINKS_DEF,
  parameter int NUM_EVENT_TYPES    = NUM_EVENT_TYPES_DEF,
  parameter int OVERFLOW_EVENT_BIT = OVERFLOW_EVENT_BIT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [PIU_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_func,
  input  logic [5:0]       in_pin,
  input  logic [7:0]       in_far_pin,
  input  logic [7:0]       in_link_param,
  input  logic             in_link_type,
  input  logic [2:0]       in_event_code,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_duplicate,
  output logic             out_limit_hit,
  output logic             out_event_present,
  output logic [3:0]       out_link_count,
  output logic [2:0]       out_slot_written
);

  plt_cmd_t    cmd;
  plt_status_t status;

  // controller
  plt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  // datapath
  plt_dp #(
    .NUM_PINS           (NUM_PINS),
    .MAX_LINKS          (MAX_LINKS),
    .NUM_EVENT_TYPES    (NUM_EVENT_TYPES),
    .OVERFLOW_EVENT_BIT (OVERFLOW_EVENT_BIT)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_func           (in_func),
    .in_pin            (in_pin),
    .in_far_pin        (in_far_pin),
    .in_link_param     (in_link_param),
    .in_link_type      (in_link_type),
    .in_event_code     (in_event_code),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_duplicate     (out_duplicate),
    .out_limit_hit     (out_limit_hit),
    .out_event_present (out_event_present),
    .out_link_count    (out_link_count),
    .out_slot_written  (out_slot_written),
    .cmd               (cmd),
    .status            (status)
  );

endmodule

FILE: design/plt_checker.sv
// ----------------------------------------------------------------------------
// plt_checker
// Port-level checks for the pin link table unit, bound to the top level.
// ----------------------------------------------------------------------------
module plt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_duplicate,
  input logic       out_limit_hit,
  input logic       out_event_present,
  input logic [3:0] out_link_count,
  input logic [2:0] out_slot_written
);

  logic       in_acc, out_acc;
  logic [1:0] pending_r;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // items accepted whose result is not yet taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_r + 2'(in_acc) - 2'(out_acc);
    end
  end

  // one item in work at a time: ready drops right after an accept
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("in_ready stayed high after an item was accepted");

  // at most one finished result waits when a new item is taken
  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> pending_r <= 2'd1)
    else $error("item accepted with two results outstanding");

  // no result without an item behind it
  a_no_extra_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> pending_r != 2'd0)
    else $error("result delivered without an accepted item");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_link_count)
      && $stable(out_slot_written) && $stable(out_duplicate)
      && $stable(out_limit_hit) && $stable(out_event_present))
    else $error("stalled result changed or dropped");

endmodule

bind pin_link_table_unit plt_checker u_plt_checker (.*);
